// ===== rtl/mme_pkg.sv =====
package mme_pkg;

    // Result kinds as seen on the output tuser
    localparam logic [1:0] KIND_MSG = 2'd0;
    localparam logic [1:0] KIND_EOT = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    // Request codes carried from the parser to the emitter
    localparam logic [1:0] REQ_MSG   = 2'd0;
    localparam logic [1:0] REQ_EOT   = 2'd1;
    localparam logic [1:0] REQ_ERR   = 2'd2;
    localparam logic [1:0] REQ_BURST = 2'd3;

    localparam int BURST_LEN = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [7:0] ST_CTRL     = 8'hb0;
    localparam logic [6:0] CC_VOLUME   = 7'd7;
    localparam logic [6:0] DATA_MAX    = 7'd127;
    localparam logic [7:0] ST_META     = 8'hff;
    localparam logic [6:0] META_EOT    = 7'h2f;
    localparam logic [1:0] LEN_THREE   = 2'd3;
    localparam logic [1:0] LEN_TWO     = 2'd2;

    typedef struct packed {
        logic [1:0]  code;
        logic        err_after;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  len;
        logic [31:0] delta;
    } req_t;

endpackage

// ===== rtl/mme_front.sv =====
module mme_front #(
    parameter int DELTA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output logic          push,
    output mme_pkg::req_t push_req
);
    import mme_pkg::*;

    localparam logic [3:0] PH_MAGIC  = 4'd0;
    localparam logic [3:0] PH_HEADER = 4'd1;
    localparam logic [3:0] PH_INSTR  = 4'd2;
    localparam logic [3:0] PH_EVENT  = 4'd3;
    localparam logic [3:0] PH_OP1    = 4'd4;
    localparam logic [3:0] PH_OP2    = 4'd5;
    localparam logic [3:0] PH_SKIP   = 4'd6;
    localparam logic [3:0] PH_VLQ    = 4'd7;
    localparam logic [3:0] PH_DRAIN  = 4'd8;

    localparam logic [2:0] EV_RELEASE = 3'd0;
    localparam logic [2:0] EV_PLAY    = 3'd1;
    localparam logic [2:0] EV_BEND    = 3'd2;
    localparam logic [2:0] EV_MODE    = 3'd3;
    localparam logic [2:0] EV_CTRL    = 3'd4;
    localparam logic [2:0] EV_END     = 3'd6;
    localparam logic [2:0] EV_UNUSED  = 3'd7;

    localparam logic [7:0] ST_OFF  = 8'h80;
    localparam logic [7:0] ST_ON   = 8'h90;
    localparam logic [7:0] ST_BEND = 8'he0;
    localparam logic [7:0] ST_PROG = 8'hc0;
    localparam logic [6:0] VEL_DEFAULT = 7'd64;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    magic_byte = 8'h4d;
            2'd1:    magic_byte = 8'h55;
            2'd2:    magic_byte = 8'h53;
            default: magic_byte = 8'h1a;
        endcase
    endfunction

    // Score channel 15 is percussion; 9..14 shift up by one
    function automatic logic [3:0] map_chan(input logic [3:0] c);
        case (c)
            4'd15:   map_chan = 4'd9;
            4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14: map_chan = c + 4'd1;
            default: map_chan = c;
        endcase
    endfunction

    // {valid, controller number}
    function automatic logic [7:0] mode_cc(input logic [6:0] num);
        case (num)
            7'd10:   mode_cc = {1'b1, 7'd120};
            7'd11:   mode_cc = {1'b1, 7'd123};
            7'd12:   mode_cc = {1'b1, 7'd126};
            7'd13:   mode_cc = {1'b1, 7'd127};
            7'd14:   mode_cc = {1'b1, 7'd121};
            default: mode_cc = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] ctrl_cc(input logic [6:0] num);
        case (num)
            7'd1:    ctrl_cc = {1'b1, 7'd0};
            7'd2:    ctrl_cc = {1'b1, 7'd1};
            7'd3:    ctrl_cc = {1'b1, 7'd7};
            7'd4:    ctrl_cc = {1'b1, 7'd10};
            7'd5:    ctrl_cc = {1'b1, 7'd11};
            7'd6:    ctrl_cc = {1'b1, 7'd91};
            7'd7:    ctrl_cc = {1'b1, 7'd93};
            7'd8:    ctrl_cc = {1'b1, 7'd64};
            7'd9:    ctrl_cc = {1'b1, 7'd67};
            default: ctrl_cc = 8'd0;
        endcase
    endfunction

    // Upper half: 8192 + x*8191/127 = 8192 + 64x + floor(63x/127)
    function automatic logic [13:0] bend_value(input logic [7:0] b);
        logic [6:0] x;
        logic [5:0] f;
        x = b[6:0];
        if (x[0] || x == 7'd0)
            f = x[6:1];
        else
            f = x[6:1] - 6'd1;
        if (!b[7])
            bend_value = {1'b0, b[6:0], 6'd0};
        else
            bend_value = 14'd8192 + {1'b0, x, 6'd0} + {8'd0, f};
    endfunction

    logic [3:0]             phase_reg, phase_next;
    logic [16:0]            cnt_reg, cnt_next;
    logic [15:0]            icount_reg, icount_next;
    logic [2:0]             etype_reg, etype_next;
    logic [3:0]             echan_reg, echan_next;
    logic                   dfollow_reg, dfollow_next;
    logic [7:0]             op1_reg, op1_next;
    logic [DELTA_WIDTH-1:0] pend_reg, pend_next;
    logic [DELTA_WIDTH-1:0] incr_reg, incr_next;
    logic [2:0]             vcnt_reg, vcnt_next;
    logic [6:0]             vel_reg [BURST_LEN];

    logic        vel_we;
    logic        vel_clear;
    logic        produce;
    logic        done;
    logic        fail;
    logic        df;
    logic [2:0]  et;
    logic [7:0]  cc;
    logic [13:0] bend;
    logic [16:0] cnt_inc;
    req_t        req;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        icount_next  = icount_reg;
        etype_next   = etype_reg;
        echan_next   = echan_reg;
        dfollow_next = dfollow_reg;
        op1_next     = op1_reg;
        pend_next    = pend_reg;
        incr_next    = incr_reg;
        vcnt_next    = vcnt_reg;
        vel_we       = 1'b0;
        vel_clear    = 1'b0;
        produce      = 1'b0;
        done         = 1'b0;
        fail         = 1'b0;
        req          = '0;
        df           = in_byte[7];
        et           = in_byte[6:4];
        cc           = 8'd0;
        bend         = bend_value(in_byte);
        cnt_inc      = cnt_reg + 17'd1;

        case (phase_reg)
            PH_MAGIC:
            begin
                if (in_byte != magic_byte(cnt_reg[1:0]))
                    fail = 1'b1;
                else if (cnt_reg[1:0] == 2'd3)
                begin
                    phase_next = PH_HEADER;
                    cnt_next   = 17'd0;
                end
                else
                    cnt_next = 17'(cnt_reg[1:0]) + 17'd1;
            end
            PH_HEADER:
            begin
                if (cnt_reg == 17'd8)
                    icount_next = {icount_reg[15:8], in_byte};
                else if (cnt_reg == 17'd9)
                    icount_next = {in_byte, icount_reg[7:0]};
                if (cnt_reg >= 17'd11)
                begin
                    cnt_next = 17'd0;
                    if (icount_reg == 16'd0)
                    begin
                        phase_next = PH_EVENT;
                        if (!in_last)
                        begin
                            pend_next = '0;
                            vel_clear = 1'b1;
                            produce   = 1'b1;
                            req.code  = REQ_BURST;
                        end
                    end
                    else
                        phase_next = PH_INSTR;
                end
                else
                    cnt_next = cnt_inc;
            end
            PH_INSTR:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= {icount_reg, 1'b0})
                begin
                    cnt_next   = 17'd0;
                    phase_next = PH_EVENT;
                    if (!in_last)
                    begin
                        pend_next = '0;
                        vel_clear = 1'b1;
                        produce   = 1'b1;
                        req.code  = REQ_BURST;
                    end
                end
            end
            PH_EVENT:
            begin
                dfollow_next = df;
                etype_next   = et;
                echan_next   = map_chan(in_byte[3:0]);
                if (et <= EV_CTRL)
                    phase_next = PH_OP1;
                else if (et == EV_UNUSED)
                    phase_next = PH_SKIP;
                else if (df)
                begin
                    phase_next = PH_VLQ;
                    incr_next  = '0;
                    vcnt_next  = 3'd0;
                end
                else if (et == EV_END)
                begin
                    produce    = 1'b1;
                    done       = 1'b1;
                    req.code   = REQ_EOT;
                    req.status = ST_META;
                    req.d1     = META_EOT;
                    req.len    = LEN_THREE;
                    req.delta  = 32'(pend_reg);
                end
            end
            PH_OP1, PH_OP2:
            begin
                req.code  = REQ_MSG;
                req.delta = 32'(pend_reg);
                req.len   = LEN_THREE;
                if (phase_reg == PH_OP1)
                begin
                    op1_next = in_byte;
                    case (etype_reg)
                        EV_RELEASE:
                        begin
                            produce    = 1'b1;
                            req.status = ST_OFF | {4'd0, echan_reg};
                            req.d1     = in_byte[6:0];
                            req.d2     = VEL_DEFAULT;
                        end
                        EV_PLAY:
                        begin
                            produce    = !in_byte[7];
                            req.status = ST_ON | {4'd0, echan_reg};
                            req.d1     = in_byte[6:0];
                            req.d2     = vel_reg[echan_reg];
                        end
                        EV_BEND:
                        begin
                            produce    = 1'b1;
                            req.status = ST_BEND | {4'd0, echan_reg};
                            req.d1     = bend[6:0];
                            req.d2     = bend[13:7];
                        end
                        EV_MODE:
                        begin
                            cc         = mode_cc(in_byte[6:0]);
                            produce    = cc[7];
                            req.status = ST_CTRL | {4'd0, echan_reg};
                            req.d1     = cc[6:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (etype_reg == EV_PLAY)
                begin
                    vel_we     = 1'b1;
                    produce    = 1'b1;
                    req.status = ST_ON | {4'd0, echan_reg};
                    req.d1     = op1_reg[6:0];
                    req.d2     = in_byte[6:0];
                end
                else if (op1_reg[6:0] == 7'd0)
                begin
                    produce    = 1'b1;
                    req.status = ST_PROG | {4'd0, echan_reg};
                    req.d1     = in_byte[6:0];
                    req.len    = LEN_TWO;
                end
                else
                begin
                    cc         = ctrl_cc(op1_reg[6:0]);
                    produce    = cc[7];
                    req.status = ST_CTRL | {4'd0, echan_reg};
                    req.d1     = cc[6:0];
                    req.d2     = in_byte[6:0];
                end
                if (produce)
                    pend_next = '0;
                // operand 2 still to come for controller or velocity note
                if (phase_reg == PH_OP1 &&
                    (etype_reg == EV_CTRL || (etype_reg == EV_PLAY && in_byte[7])))
                    phase_next = PH_OP2;
                else if (dfollow_reg)
                begin
                    phase_next = PH_VLQ;
                    incr_next  = '0;
                    vcnt_next  = 3'd0;
                end
                else
                    phase_next = PH_EVENT;
            end
            PH_SKIP:
            begin
                if (dfollow_reg)
                begin
                    phase_next = PH_VLQ;
                    incr_next  = '0;
                    vcnt_next  = 3'd0;
                end
                else
                    phase_next = PH_EVENT;
            end
            PH_VLQ:
            begin
                incr_next = DELTA_WIDTH'({incr_reg, in_byte[6:0]});
                vcnt_next = vcnt_reg + 3'd1;
                if (!in_byte[7])
                begin
                    pend_next  = pend_reg + incr_next;
                    phase_next = PH_EVENT;
                    if (etype_reg == EV_END)
                    begin
                        produce    = 1'b1;
                        done       = 1'b1;
                        req.code   = REQ_EOT;
                        req.status = ST_META;
                        req.d1     = META_EOT;
                        req.len    = LEN_THREE;
                        req.delta  = 32'(pend_next);
                    end
                end
                else if (vcnt_next >= 3'd4)
                    fail = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (fail || (in_last && !done && phase_next <= PH_VLQ))
        begin
            // append the error; it takes the whole request when nothing else was made
            if (produce)
                req.err_after = 1'b1;
            else
                req = '{code: REQ_ERR, default: '0};
            produce    = 1'b1;
            phase_next = in_last ? PH_MAGIC : PH_DRAIN;
            cnt_next   = 17'd0;
        end
        else if (done || in_last)
        begin
            phase_next = in_last ? PH_MAGIC : PH_DRAIN;
            cnt_next   = 17'd0;
        end
        else if (phase_next > PH_DRAIN)
            phase_next = PH_DRAIN;
    end

    assign push     = in_fire && produce;
    assign push_req = req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC;
            cnt_reg     <= '0;
            icount_reg  <= '0;
            etype_reg   <= '0;
            echan_reg   <= '0;
            dfollow_reg <= 1'b0;
            op1_reg     <= '0;
            pend_reg    <= '0;
            incr_reg    <= '0;
            vcnt_reg    <= '0;
            for (int i = 0; i < BURST_LEN; i++)
                vel_reg[i] <= VEL_DEFAULT;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            icount_reg  <= icount_next;
            etype_reg   <= etype_next;
            echan_reg   <= echan_next;
            dfollow_reg <= dfollow_next;
            op1_reg     <= op1_next;
            pend_reg    <= pend_next;
            incr_reg    <= incr_next;
            vcnt_reg    <= vcnt_next;
            if (vel_clear)
            begin
                for (int i = 0; i < BURST_LEN; i++)
                    vel_reg[i] <= VEL_DEFAULT;
            end
            else if (vel_we)
                vel_reg[echan_reg] <= in_byte[6:0];
        end
    end

endmodule

// ===== rtl/mme_queue.sv =====
module mme_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mme_pkg::req_t push_req,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mme_pkg::req_t head_req
);
    import mme_pkg::*;

    req_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/mme_back.sv =====
module mme_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  mme_pkg::req_t head_req,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_kind,
    output logic [7:0]    out_status,
    output logic [6:0]    out_d1,
    output logic [6:0]    out_d2,
    output logic [1:0]    out_len,
    output logic [31:0]   out_delta,
    output logic          out_last
);
    import mme_pkg::*;

    logic [3:0]  step_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  status_reg;
    logic [6:0]  d1_reg;
    logic [6:0]  d2_reg;
    logic [1:0]  len_reg;
    logic [31:0] delta_reg;
    logic        last_reg;

    logic        load;
    logic        is_last;
    logic        is_err;
    logic [1:0]  kind_next;
    logic [7:0]  status_next;
    logic [6:0]  d1_next;
    logic [6:0]  d2_next;
    logic [1:0]  len_next;
    logic [31:0] delta_next;

    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && is_last;

    always_comb
    begin
        is_err      = (head_req.code == REQ_ERR) || (step_reg != 4'd0);
        kind_next   = KIND_MSG;
        status_next = head_req.status;
        d1_next     = head_req.d1;
        d2_next     = head_req.d2;
        len_next    = head_req.len;
        delta_next  = head_req.delta;
        if (head_req.code == REQ_BURST)
        begin
            is_last     = (step_reg == 4'(BURST_LEN - 1));
            status_next = ST_CTRL | {4'd0, step_reg};
            d1_next     = CC_VOLUME;
            d2_next     = DATA_MAX;
            len_next    = LEN_THREE;
            delta_next  = '0;
        end
        else
        begin
            is_last = is_err || !head_req.err_after;
            if (is_err)
            begin
                kind_next   = KIND_ERR;
                status_next = '0;
                d1_next     = '0;
                d2_next     = '0;
                len_next    = '0;
                delta_next  = '0;
            end
            else if (head_req.code == REQ_EOT)
                kind_next = KIND_EOT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_next;
            status_reg <= status_next;
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            len_reg    <= len_next;
            delta_reg  <= delta_next;
            last_reg   <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            if (load)
                step_reg <= is_last ? 4'd0 : step_reg + 4'd1;
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_status = status_reg;
    assign out_d1     = d1_reg;
    assign out_d2     = d2_reg;
    assign out_len    = len_reg;
    assign out_delta  = delta_reg;
    assign out_last   = last_reg;

endmodule

// ===== rtl/mus_to_midi_event_converter_top.sv =====
// Score-to-MIDI event converter. Feed one byte of the score file per request on
// the slave side, with s_tlast on the final byte of the file. A parser stage
// classifies the byte and posts at most one request into a four-entry queue; an
// emitter drains the queue at one result per cycle into the output register
// while m_tready does not stall it. Most bytes yield zero or one result (two
// when a message is followed by a format error), so the stream sustains one
// byte per cycle while the queue is not full; the byte that finishes the
// instrument list yields sixteen volume results, and the parser keeps accepting
// until the queue fills. m_tuser carries the result kind (message, end of track,
// format error) and m_tlast marks the last result of a byte. DELTA_WIDTH sets
// the width of the delta accumulator; m_tdata shows its low 32 bits.
module mus_to_midi_event_converter_top #(
    parameter int DELTA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tlast,   // end_of_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] status_byte, [14:8] first_data,
                                   // [21:15] second_data, [23:22] message_length,
                                   // [55:24] delta_ticks
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // last_of_run
);
    import mme_pkg::*;

    logic        q_full;
    logic        push;
    req_t        push_req;
    logic        pop;
    logic        head_valid;
    req_t        head_req;
    logic [7:0]  status;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [1:0]  len;
    logic [31:0] delta;

    assign s_tready = !q_full;

    mme_front #(
        .DELTA_WIDTH (DELTA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_tvalid && s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .push_req (push_req)
    );

    mme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (push_req),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    mme_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_status (status),
        .out_d1     (d1),
        .out_d2     (d2),
        .out_len    (len),
        .out_delta  (delta),
        .out_last   (m_tlast)
    );

    assign m_tdata = {delta, len, d2, d1, status};

endmodule

// ===== rtl/mme_checker.sv =====
module mme_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import mme_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ERR |-> m_tlast && m_tdata == '0)
        else $error("format error not last or not zero");

    a_eot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_EOT |->
            m_tlast && m_tdata[23:0] == {LEN_THREE, 7'd0, META_EOT, ST_META})
        else $error("malformed end of track");

    a_msg_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_MSG |->
            m_tdata[7] && (m_tdata[23:22] == LEN_TWO || m_tdata[23:22] == LEN_THREE))
        else $error("bad message length or status");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined result kind");

endmodule

bind mus_to_midi_event_converter_top mme_checker u_mme_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
